[rtl/pairwise_probability_coupling_assert.svh]
// Assertion macros shared by the coupling block.
`ifndef PAIRWISE_PROBABILITY_COUPLING_ASSERT_SVH
`define PAIRWISE_PROBABILITY_COUPLING_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ppc_pkg.sv]
package ppc_pkg;

  localparam int unsigned IdxW   = 4;
  localparam int unsigned ProbW  = 17;
  localparam int unsigned KW     = 5;
  localparam int unsigned TotW   = 22;
  localparam int unsigned IndexCap = 16;
  localparam logic [ProbW-1:0] OneQ16 = 17'h10000;

  // Divider operations.
  typedef enum logic [1:0] {
    DIV_RECIP = 2'd0,
    DIV_SCORE = 2'd1,
    DIV_NORM  = 2'd2
  } div_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic           store_pair;
    logic           clear_acc;
    logic           rd_req;     // read pair_store at (ci, cj)
    logic           acc_recip;  // add divider quotient into accumulator
    logic           mark_zero;  // a zero probability was read
    logic           div_start;
    div_op_e        div_op;
    logic           save_score; // write score of class ci
    logic           clear_total;
    logic           clr_row;    // clear every valid bit of the store
    logic [IdxW-1:0] ci;
    logic [IdxW-1:0] cj;
  } ppc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic rd_zero;
    logic total_zero;
  } ppc_stat_t;

endpackage

[rtl/ppc_div.sv]
// Restoring divider, one quotient bit per cycle.
module ppc_div import ppc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [48:0] num_i,
  input  logic [36:0] den_i,
  output logic        done_o,
  output logic [48:0] quot_o
);

  logic [48:0] quot_q, quot_d;
  logic [37:0] rem_q, rem_d;
  logic [36:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [37:0] trial;

  assign trial  = {rem_q[36:0], quot_q[48]};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd49;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[47:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

endmodule

[rtl/ppc_datapath.sv]
module ppc_datapath import ppc_pkg::*; #(
  parameter int unsigned MaxClasses = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ppc_cmd_t         cmd_i,
  input  logic [IdxW-1:0]  a_i,
  input  logic [IdxW-1:0]  b_i,
  input  logic [ProbW-1:0] r_i,
  input  logic [KW-1:0]    k_i,
  output ppc_stat_t        stat_o,
  output logic [ProbW-1:0] prob_o
);

  localparam int unsigned Rows = (MaxClasses < IndexCap) ? MaxClasses : IndexCap;
  localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned AddrW = $clog2(Rows*Rows);

  // Pair store with one valid bit per entry; the valid bits are cleared together.
  logic [ProbW-1:0] store_q [Rows*Rows];
  logic [Rows*Rows-1:0] vld_q;
  logic [ProbW-1:0] rd_q;
  logic [ProbW-1:0] rsat;
  logic [ProbW-1:0] score_q [Rows];
  logic [TotW-1:0]  total_q;
  logic [36:0]      acc_q;
  logic             zero_q;
  logic             dstart;
  logic [48:0]      dnum, dquot;
  logic [36:0]      dden, denom;
  logic             ddone;
  logic [RowW-1:0]  ra, rb;
  logic [AddrW-1:0] wr_ab, wr_ba, rd_addr;

  assign rsat  = (r_i > OneQ16) ? OneQ16 : r_i;
  assign ra    = a_i[RowW-1:0];
  assign rb    = b_i[RowW-1:0];
  assign wr_ab = AddrW'(ra * Rows + rb);
  assign wr_ba = AddrW'(rb * Rows + ra);
  assign rd_addr = AddrW'(cmd_i.ci[RowW-1:0] * Rows + cmd_i.cj[RowW-1:0]);
  assign denom = acc_q - 37'({k_i - 5'd2, 16'h0});
  assign dstart = cmd_i.div_start;

  always_comb begin
    dnum = 49'h1_0000_0000;
    dden = 37'(rd_q);
    unique case (cmd_i.div_op)
      DIV_RECIP: dden = 37'(rd_q);
      DIV_SCORE: dden = denom;
      DIV_NORM: begin
        dnum = 49'({score_q[cmd_i.ci[RowW-1:0]], 16'h0});
        dden = 37'(total_q);
      end
      default: dden = 37'(rd_q);
    endcase
  end

  ppc_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .done_o(ddone), .quot_o(dquot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_pair) begin
      store_q[wr_ab] <= rsat;
      store_q[wr_ba] <= OneQ16 - rsat;
    end
    if (cmd_i.rd_req)
      rd_q <= vld_q[rd_addr] ? store_q[rd_addr] : '0;
    if (cmd_i.save_score)
      score_q[cmd_i.ci[RowW-1:0]] <= (zero_q || denom == '0) ? '0 : dquot[ProbW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      total_q <= '0;
      acc_q   <= '0;
      zero_q  <= 1'b0;
    end else begin
      if (cmd_i.store_pair) begin
        vld_q[wr_ab] <= 1'b1;
        vld_q[wr_ba] <= 1'b1;
      end
      if (cmd_i.clr_row)
        vld_q <= '0;
      if (cmd_i.clear_acc) begin
        acc_q  <= '0;
        zero_q <= 1'b0;
      end
      if (cmd_i.acc_recip) acc_q <= acc_q + dquot[36:0];
      if (cmd_i.mark_zero) zero_q <= 1'b1;
      if (cmd_i.clear_total) total_q <= '0;
      else if (cmd_i.save_score)
        total_q <= total_q + TotW'((zero_q || denom == '0) ? '0 : dquot[ProbW-1:0]);
    end
  end

  assign prob_o = dquot[ProbW-1:0];
  assign stat_o.div_done   = ddone;
  assign stat_o.rd_zero    = (rd_q == '0);
  assign stat_o.total_zero = (total_q == '0);

endmodule

[rtl/ppc_ctrl.sv]
`include "pairwise_probability_coupling_assert.svh"
module ppc_ctrl import ppc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_req_i,
  input  logic            last_i,
  input  logic            pair_ok_i,
  input  logic [KW-1:0]   k_i,
  input  ppc_stat_t       stat_i,
  input  logic            out_ready_i,
  output logic            in_ready_o,
  output ppc_cmd_t        cmd_o,
  output logic            out_valid_o,
  output logic            degen_o,
  output logic            out_last_o,
  output logic [IdxW-1:0] out_idx_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_RECIP, S_SCORE, S_NORM, S_EMIT
  } state_e;

  state_e          state_q;
  logic [IdxW-1:0] ci_q, cj_q;
  logic            out_valid_q, degen_q;
  logic            busy_div_q;
  logic [IdxW-1:0] kmax;

  assign kmax = IdxW'(k_i - 5'd1);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign degen_o     = degen_q;
  assign out_last_o  = (ci_q == kmax);
  assign out_idx_o   = ci_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.ci = ci_q;
    cmd_o.cj = cj_q;
    cmd_o.div_op = DIV_RECIP;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.store_pair  = in_req_i && pair_ok_i;
        cmd_o.clear_acc   = in_req_i && last_i;
        cmd_o.clear_total = in_req_i && last_i;
      end
      S_READ:  cmd_o.rd_req = (cj_q != ci_q);
      S_CHECK: begin
        cmd_o.mark_zero = stat_i.rd_zero;
        cmd_o.div_start = !stat_i.rd_zero;
      end
      S_RECIP: cmd_o.acc_recip = stat_i.div_done;
      S_SCORE: begin
        cmd_o.div_op    = DIV_SCORE;
        cmd_o.div_start = !busy_div_q;
        cmd_o.save_score = busy_div_q && stat_i.div_done;
        // The next class starts from an empty accumulator.
        cmd_o.clear_acc  = busy_div_q && stat_i.div_done;
      end
      S_NORM: begin
        cmd_o.div_op    = DIV_NORM;
        cmd_o.div_start = !busy_div_q && !stat_i.total_zero;
      end
      S_EMIT: cmd_o.clr_row = out_ready_i && (ci_q == kmax);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ci_q        <= '0;
      cj_q        <= '0;
      out_valid_q <= 1'b0;
      degen_q     <= 1'b0;
      busy_div_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_req_i && last_i) begin
          ci_q <= '0;
          cj_q <= '0;
          state_q <= S_READ;
        end
        S_READ: begin
          if (cj_q == ci_q) begin
            if (cj_q == kmax) state_q <= S_SCORE;
            else cj_q <= cj_q + 1'b1;
          end else state_q <= S_CHECK;
        end
        S_CHECK: state_q <= stat_i.rd_zero ? S_SCORE : S_RECIP;
        S_RECIP: if (stat_i.div_done) begin
          if (cj_q == kmax) state_q <= S_SCORE;
          else begin
            cj_q <= cj_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_SCORE: begin
          if (!busy_div_q) busy_div_q <= 1'b1;
          else if (stat_i.div_done) begin
            busy_div_q <= 1'b0;
            cj_q <= '0;
            if (ci_q == kmax) begin
              ci_q <= '0;
              state_q <= S_NORM;
            end else begin
              ci_q <= ci_q + 1'b1;
              state_q <= S_READ;
            end
          end
        end
        S_NORM: begin
          if (stat_i.total_zero) begin
            degen_q <= 1'b1;
            out_valid_q <= 1'b1;
            state_q <= S_EMIT;
          end else if (!busy_div_q) busy_div_q <= 1'b1;
          else if (stat_i.div_done) begin
            busy_div_q <= 1'b0;
            degen_q <= 1'b0;
            out_valid_q <= 1'b1;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: if (out_ready_i) begin
          out_valid_q <= 1'b0;
          if (ci_q == kmax) state_q <= S_IDLE;
          else begin
            ci_q <= ci_q + 1'b1;
            state_q <= S_NORM;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Results are offered only while emitting and never overlap intake.
  `PPC_ASSERT_IMP(a_no_out_idle, clk_i, rst_ni, out_valid_q, state_q == S_EMIT)
  `PPC_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, !out_valid_q)
  `PPC_ASSERT_NEXT(a_emit_hold, clk_i, rst_ni, out_valid_q && !out_ready_i,
                   out_valid_q && $stable(ci_q))

endmodule

[rtl/pairwise_probability_coupling.sv]
// Channel   | Direction | Payload
// s_axis    | in        | tdata: first_class, second_class, pair_probability; tlast: last_pair
// m_axis    | out       | tdata: class_index, class_probability; tuser: degenerate; tlast
// cfg       | in        | class_count
// A pair without tlast is stored if its classes are distinct and in range; the input stays
// ready. A pair with tlast starts the scoring on one shared bit-serial divider (49 iterations):
// per class it sums the reciprocals of the stored probabilities against the other classes,
// then divides for the score; a zero probability ends that class early. Each result is the
// score over the total, or zero and degenerate when every score is zero. Reset clears control
// state and the valid bits at once. The input stays stalled until the last class result is taken.
module pairwise_probability_coupling import ppc_pkg::*; #(
  parameter int unsigned MAX_CLASSES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // first_class[3:0], second_class[7:4], pair_probability[24:8]
  input  logic        s_axis_tlast,  // last_pair
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // class_index[3:0], class_probability[20:4]
  output logic        m_axis_tuser,  // degenerate
  output logic        m_axis_tlast,  // last_class
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i     // class_count
);

  localparam int unsigned Cap = (MAX_CLASSES < IndexCap) ? MAX_CLASSES : IndexCap;

  logic [KW-1:0]    kreg_q, k_eff;
  ppc_cmd_t         cmd;
  ppc_stat_t        stat;
  logic [ProbW-1:0] prob;
  logic             degen, pair_ok;
  logic [IdxW-1:0]  a, b, oidx;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) kreg_q <= KW'(2);
    else if (cfg_valid_i) kreg_q <= cfg_data_i;
  end

  assign k_eff = (kreg_q < KW'(2)) ? KW'(2) : (kreg_q > KW'(Cap)) ? KW'(Cap) : kreg_q;
  assign a = s_axis_tdata[3:0];
  assign b = s_axis_tdata[7:4];
  assign pair_ok = (a != b) && (KW'(a) < k_eff) && (KW'(b) < k_eff);

  ppc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_req_i(s_axis_tvalid && s_axis_tready), .last_i(s_axis_tlast),
    .pair_ok_i(pair_ok), .k_i(k_eff), .stat_i(stat), .out_ready_i(m_axis_tready),
    .in_ready_o(s_axis_tready), .cmd_o(cmd), .out_valid_o(m_axis_tvalid),
    .degen_o(degen), .out_last_o(m_axis_tlast), .out_idx_o(oidx)
  );

  ppc_datapath #(.MaxClasses(MAX_CLASSES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .a_i(a), .b_i(b), .r_i(s_axis_tdata[24:8]),
    .k_i(k_eff), .stat_o(stat), .prob_o(prob)
  );

  assign m_axis_tuser = degen;
  assign m_axis_tdata = {3'b0, degen ? 17'h0 : prob, oidx};

endmodule
